### sv/rrsg_pkg.sv
package rrsg_pkg;

	// sizing of the corner ellipse and the span store
	localparam int MAX_ROWS         = 64;
	localparam int MAX_CORNER_WIDTH = 128;
	localparam int STEP_LIMIT       = 2 * MAX_CORNER_WIDTH + 2 * MAX_ROWS + 16;

	localparam int COORD_W  = 16;
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int H_W      = $clog2(MAX_ROWS + 1);
	localparam int W_W      = $clog2(MAX_CORNER_WIDTH + 1);
	localparam int COL_W    = $clog2(MAX_CORNER_WIDTH / 2 + 2);
	localparam int ITER_W   = $clog2(STEP_LIMIT + 1);
	localparam int ROWCNT_W = $clog2(MAX_ROWS / 2 + STEP_LIMIT + 1);
	// error term grows with the squared radius and the squared step count
	localparam int ACC_W    = 2 * W_W + 2 * ITER_W + 6;

	// request item
	typedef struct packed {
		logic signed [COORD_W-1:0] rect_left;
		logic signed [COORD_W-1:0] rect_top;
		logic signed [COORD_W-1:0] rect_right;
		logic signed [COORD_W-1:0] rect_bottom;
		logic signed [COORD_W-1:0] corner_width;
		logic signed [COORD_W-1:0] corner_height;
	} req_t;

	// result item
	typedef struct packed {
		logic signed [COORD_W-1:0] span_left;
		logic signed [COORD_W-1:0] span_right;
		logic signed [COORD_W-1:0] span_top;
		logic signed [COORD_W-1:0] span_bottom;
		logic                      is_empty;
		logic                      is_last;
	} span_t;

	// kick-off of the ellipse stepper
	typedef struct packed {
		logic               go;
		logic [W_W-1:0]     w;
		logic [H_W-1:0]     h;
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] right;
	} rrsg_start_t;

	// span store write from the stepper
	typedef struct packed {
		logic               vld;
		logic [ROW_W-1:0]   addr;
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] right;
	} rrsg_wr_t;

	typedef struct packed {
		logic     done;
		rrsg_wr_t wr;
	} rrsg_step_t;

endpackage

### sv/rrsg_stepper.sv
module rrsg_stepper import rrsg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  rrsg_start_t start,
	output rrsg_step_t  res
);

	localparam logic [2:0] SP_IDLE = 3'd0;
	localparam logic [2:0] SP_SQ   = 3'd1;
	localparam logic [2:0] SP_MUL  = 3'd2;
	localparam logic [2:0] SP_INIT = 3'd3;
	localparam logic [2:0] SP_STEP = 3'd4;

	localparam int SQ_W   = 2 * W_W + 2;
	localparam int PROD_W = 2 * ROW_W + W_W + 2;
	localparam int CMP_W  = W_W + 1;

	logic [2:0]                state_q;
	logic [W_W-1:0]            w_q;
	logic [ROW_W-1:0]          b_q;
	logic [COORD_W-1:0]        left_q;
	logic [COORD_W-1:0]        right_q;
	logic [2*W_W-1:0]          a_sq_q;
	logic [2*ROW_W-1:0]        b_sq_q;
	logic signed [ACC_W-1:0]   sx_q;
	logic signed [ACC_W-1:0]   sy_q;
	logic signed [ACC_W-1:0]   asq_q;
	logic signed [ACC_W-1:0]   bsq_q;
	logic signed [ACC_W-1:0]   err_q;
	logic [COL_W-1:0]          col_q;
	logic [ROWCNT_W-1:0]       row_q;
	logic [ITER_W-1:0]         iter_q;

	logic signed [W_W:0]       a_val;
	logic signed [W_W:0]       one_minus_a;
	logic signed [SQ_W-1:0]    a_sq_full;
	logic signed [PROD_W-1:0]  sx_prod;
	logic signed [ACC_W:0]     e2;
	logic                      cx;
	logic                      cy;
	logic                      run;
	logic signed [ACC_W-1:0]   sx_n;
	logic signed [ACC_W-1:0]   sy_n;
	logic signed [ACC_W-1:0]   err_n;
	logic [COL_W-1:0]          col_n;
	logic [ROWCNT_W-1:0]       row_n;

	// set-up arithmetic: a = w - 1, b = h - 1
	assign a_val       = $signed({1'b0, w_q}) - (W_W+1)'(1);
	assign one_minus_a = (W_W+1)'(2) - $signed({1'b0, w_q});
	assign a_sq_full   = SQ_W'(a_val) * SQ_W'(a_val);
	assign sx_prod     = PROD_W'($signed({1'b0, b_sq_q})) * PROD_W'(one_minus_a);

	// one stepping iteration
	assign e2    = {err_q, 1'b0};
	assign cx    = e2 >= (ACC_W+1)'(sx_q);
	assign cy    = e2 <= (ACC_W+1)'(sy_q);
	assign sx_n  = sx_q + bsq_q;
	assign sy_n  = sy_q + asq_q;
	assign err_n = err_q + (cx ? sx_n : '0) + (cy ? sy_n : '0);
	assign col_n = col_q + COL_W'(cx);
	assign row_n = row_q + ROWCNT_W'(cy);
	assign run   = (iter_q < ITER_W'(STEP_LIMIT)) && (CMP_W'(col_q) <= CMP_W'(w_q >> 1));

	// store writes and completion
	always_comb begin
		res = '0;
		unique case (state_q)
			SP_SQ: begin
				res.wr.vld   = 1'b1;
				res.wr.addr  = row_q[ROW_W-1:0];
				res.wr.left  = left_q;
				res.wr.right = right_q;
			end
			SP_STEP: begin
				if (run) begin
					res.wr.vld   = cy && (row_n < ROWCNT_W'(MAX_ROWS));
					res.wr.addr  = row_n[ROW_W-1:0];
					res.wr.left  = left_q + COORD_W'(col_n);
					res.wr.right = right_q - COORD_W'(col_n);
				end else begin
					res.done = 1'b1;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SP_IDLE;
		end else begin
			unique case (state_q)
				SP_IDLE: if (start.go) state_q <= SP_SQ;
				SP_SQ:   state_q <= SP_MUL;
				SP_MUL:  state_q <= SP_INIT;
				SP_INIT: state_q <= SP_STEP;
				SP_STEP: if (!run) state_q <= SP_IDLE;
				default: state_q <= SP_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			SP_IDLE: begin
				if (start.go) begin
					w_q     <= start.w;
					b_q     <= ROW_W'(start.h - H_W'(1));
					left_q  <= start.left;
					right_q <= start.right;
					row_q   <= ROWCNT_W'(start.h >> 1);
				end
			end
			SP_SQ: begin
				a_sq_q <= a_sq_full[2*W_W-1:0];
				b_sq_q <= b_q * b_q;
			end
			SP_MUL: begin
				sx_q  <= ACC_W'(sx_prod) <<< 2;
				sy_q  <= b_q[0] ? ($signed(ACC_W'(a_sq_q)) <<< 3)
				                : ($signed(ACC_W'(a_sq_q)) <<< 2);
				asq_q <= $signed(ACC_W'(a_sq_q)) <<< 3;
				bsq_q <= $signed(ACC_W'(b_sq_q)) <<< 3;
			end
			SP_INIT: begin
				err_q  <= sx_q + sy_q + (b_q[0] ? $signed(ACC_W'(a_sq_q)) : '0);
				col_q  <= '0;
				iter_q <= '0;
			end
			SP_STEP: begin
				if (run) begin
					if (cx) sx_q <= sx_n;
					if (cy) sy_q <= sy_n;
					err_q  <= err_n;
					col_q  <= col_n;
					row_q  <= row_n;
					iter_q <= iter_q + ITER_W'(1);
				end
			end
			default: begin
				col_q <= col_q;
			end
		endcase
	end

endmodule

### sv/round_rect_span_generator_unit.sv
// Rounded-rectangle span generator. Each request item gives a rectangle with exclusive right
// and bottom edges and a corner ellipse size; the block answers with one span item per ellipse
// row (h items, h = corner height limited by the rectangle and by MAX_ROWS), the last one
// flagged is_last, or a single is_empty item when h comes out zero or negative. Per request:
// sizing and set-up multiplies, then one ellipse step per cycle (roughly w/2 + h/2 steps, at
// most STEP_LIMIT), then a mirror of the lower half of the row store into the upper half, then
// the spans, held while the output is stalled. The row store is not cleared: rows that the
// stepping does not reach keep what an earlier request left there. A new request is taken as
// soon as the last span has been read from the row store, before that span has left the block.
module round_rect_span_generator_unit import rrsg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_stall,
	input  req_t  req,
	output logic  span_valid,
	input  logic  span_stall,
	output span_t span
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SIZE   = 3'd1;
	localparam logic [2:0] ST_START  = 3'd2;
	localparam logic [2:0] ST_STEP   = 3'd3;
	localparam logic [2:0] ST_MIRROR = 3'd4;
	localparam logic [2:0] ST_EMIT   = 3'd5;
	localparam logic [2:0] ST_EMPTY  = 3'd6;

	localparam int SZ_W = COORD_W + 2;

	logic [2:0]          state_q;
	req_t                req_q;
	logic [W_W-1:0]      w_q;
	logic [H_W-1:0]      h_q;
	logic                h_pos_q;
	logic [COORD_W-1:0]  base_q;
	logic [ROW_W-1:0]    half_q;
	logic [ROW_W-1:0]    last_q;
	logic [ROW_W-1:0]    idx_q;
	logic                mir_wr_s1;
	logic [ROW_W-1:0]    mir_addr_s1;
	logic                rd_s1;
	logic [COORD_W-1:0]  t_s1;
	logic [COORD_W-1:0]  bt_s1;
	logic                last_s1;
	logic                out_vld_q;
	span_t               span_q;

	// row store
	logic [COORD_W-1:0]  left_mem  [MAX_ROWS];
	logic [COORD_W-1:0]  right_mem [MAX_ROWS];
	logic [COORD_W-1:0]  rd_left_q;
	logic [COORD_W-1:0]  rd_right_q;
	logic [ROW_W-1:0]    rd_addr;
	logic                wr_en;
	logic [ROW_W-1:0]    wr_addr;
	logic [COORD_W-1:0]  wr_left;
	logic [COORD_W-1:0]  wr_right;

	rrsg_start_t         start;
	rrsg_step_t          step;

	logic signed [SZ_W-1:0] dx;
	logic signed [SZ_W-1:0] dy;
	logic signed [SZ_W-1:0] cw_abs;
	logic signed [SZ_W-1:0] ch_abs;
	logic signed [SZ_W-1:0] w_raw;
	logic signed [SZ_W-1:0] h_raw;
	logic [W_W-1:0]         w_sat;
	logic [H_W-1:0]         h_sat;

	logic                out_free;
	logic                emit_go;
	logic                empty_go;
	logic                lower;
	logic [COORD_W-1:0]  t_lo;
	logic [COORD_W-1:0]  t_hi;
	logic [COORD_W-1:0]  t_val;
	logic [COORD_W-1:0]  bt_val;

	// corner size from the request, limited by the rectangle
	always_comb begin
		dx     = SZ_W'(req_q.rect_right) - SZ_W'(1) - SZ_W'(req_q.rect_left);
		dy     = SZ_W'(req_q.rect_bottom) - SZ_W'(1) - SZ_W'(req_q.rect_top);
		cw_abs = req_q.corner_width[COORD_W-1] ? -SZ_W'(req_q.corner_width)
		                                       : SZ_W'(req_q.corner_width);
		ch_abs = req_q.corner_height[COORD_W-1] ? -SZ_W'(req_q.corner_height)
		                                        : SZ_W'(req_q.corner_height);
		w_raw  = (dx < cw_abs) ? dx : cw_abs;
		h_raw  = (dy < ch_abs) ? dy : ch_abs;
		priority if (w_raw > SZ_W'(MAX_CORNER_WIDTH)) begin
			w_sat = W_W'(MAX_CORNER_WIDTH);
		end else if (w_raw < 0) begin
			w_sat = '0;
		end else begin
			w_sat = W_W'(w_raw);
		end
		h_sat = (h_raw > SZ_W'(MAX_ROWS)) ? H_W'(MAX_ROWS) : H_W'(h_raw);
	end

	// ellipse stepper
	always_comb begin
		start.go    = (state_q == ST_START) && h_pos_q;
		start.w     = w_q;
		start.h     = h_q;
		start.left  = req_q.rect_left;
		start.right = req_q.rect_right - COORD_W'(1);
	end

	rrsg_stepper u_stepper (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.res    (step)
	);

	// store port selection: mirror copies never overlap stepper writes
	assign wr_en    = step.wr.vld || mir_wr_s1;
	assign wr_addr  = mir_wr_s1 ? mir_addr_s1 : step.wr.addr;
	assign wr_left  = mir_wr_s1 ? rd_left_q : step.wr.left;
	assign wr_right = mir_wr_s1 ? rd_right_q : step.wr.right;
	assign rd_addr  = (state_q == ST_MIRROR) ? (last_q - idx_q) : idx_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			left_mem[wr_addr]  <= wr_left;
			right_mem[wr_addr] <= wr_right;
		end
		rd_left_q  <= left_mem[rd_addr];
		rd_right_q <= right_mem[rd_addr];
	end

	// span rows: upper half counts down from top, lower half up to bottom
	assign out_free = !out_vld_q || !span_stall;
	assign emit_go  = (state_q == ST_EMIT) && !rd_s1 && !mir_wr_s1 && out_free;
	assign empty_go = (state_q == ST_EMPTY) && !rd_s1 && out_free;
	assign lower    = idx_q < half_q;
	assign t_lo     = req_q.rect_top + COORD_W'(idx_q);
	assign t_hi     = base_q + COORD_W'(idx_q);
	assign bt_val   = (lower ? t_lo : t_hi) + COORD_W'(1);
	assign t_val    = lower ? t_lo
	                : (idx_q == half_q) ? (req_q.rect_top + COORD_W'(half_q)) : t_hi;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			mir_wr_s1   <= 1'b0;
			mir_addr_s1 <= '0;
			rd_s1       <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			mir_wr_s1 <= 1'b0;
			rd_s1     <= emit_go;
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) state_q <= ST_SIZE;
				end
				ST_SIZE: begin
					state_q <= ST_START;
				end
				ST_START: begin
					state_q <= h_pos_q ? ST_STEP : ST_EMPTY;
				end
				ST_STEP: begin
					if (step.done) begin
						idx_q   <= '0;
						state_q <= (half_q == '0) ? ST_EMIT : ST_MIRROR;
					end
				end
				ST_MIRROR: begin
					mir_wr_s1   <= 1'b1;
					mir_addr_s1 <= idx_q;
					if (idx_q == half_q - ROW_W'(1)) begin
						idx_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						idx_q <= idx_q + ROW_W'(1);
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						if (idx_q == last_q) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + ROW_W'(1);
						end
					end
				end
				ST_EMPTY: begin
					if (empty_go) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// output register
			priority if (rd_s1 || empty_go) begin
				out_vld_q <= 1'b1;
			end else if (!span_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// request fields, sizes and span payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			req_q <= req;
		end
		if (state_q == ST_SIZE) begin
			w_q     <= w_sat;
			h_q     <= h_sat;
			h_pos_q <= h_raw > 0;
		end
		if (state_q == ST_START) begin
			base_q <= req_q.rect_bottom - COORD_W'(1) - COORD_W'(h_q);
			half_q <= ROW_W'(h_q >> 1);
			last_q <= ROW_W'(h_q - H_W'(1));
		end
		if (emit_go) begin
			t_s1    <= t_val;
			bt_s1   <= bt_val;
			last_s1 <= idx_q == last_q;
		end
		priority if (rd_s1) begin
			span_q.span_left   <= rd_left_q;
			span_q.span_right  <= rd_right_q;
			span_q.span_top    <= t_s1;
			span_q.span_bottom <= bt_s1;
			span_q.is_empty    <= 1'b0;
			span_q.is_last     <= last_s1;
		end else if (empty_go) begin
			span_q.span_left   <= '0;
			span_q.span_right  <= '0;
			span_q.span_top    <= '0;
			span_q.span_bottom <= '0;
			span_q.is_empty    <= 1'b1;
			span_q.is_last     <= 1'b1;
		end else begin
			span_q <= span_q;
		end
	end

	assign req_stall  = state_q != ST_IDLE;
	assign span_valid = out_vld_q;
	assign span       = span_q;

`ifndef SYNTHESIS
	a_load_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 |-> (!out_vld_q || !span_stall))
		else $error("span register overwritten while stalled");
	a_single_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(step.wr.vld && mir_wr_s1))
		else $error("stepper and mirror write the row store together");
	a_no_step_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> !step.wr.vld)
		else $error("stepper write during emit");
	a_mirror_upper: assert property (@(posedge clk) disable iff (!arst_n)
		mir_wr_s1 |-> (mir_addr_s1 < half_q))
		else $error("mirror write outside the upper half");
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(span_valid && span.is_empty) |-> span.is_last)
		else $error("empty item not marked last");
`endif

endmodule
